// ----- rtl/dtcf_pkg.sv -----
// Shared types and constants for the binary64 to narrow float converter.
// No dependencies.
`timescale 1ns / 1ps

package dtcf_pkg;

  localparam int unsigned SrcWidth  = 64;
  localparam int unsigned ManWidth  = 52;
  localparam int unsigned BexpWidth = 11;
  localparam int unsigned TwWidth   = 7;
  localparam int unsigned EwWidth   = 4;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned TdataOutW = 64;
  localparam int unsigned TuserOutW = 2;

  localparam logic [CfgIdxW-1:0] RegTotalWidth = 1'd0;
  localparam logic [CfgIdxW-1:0] RegExpWidth   = 1'd1;

  localparam logic [TwWidth-1:0] TotalWidthReset = 7'd16;
  localparam logic [EwWidth-1:0] ExpWidthReset   = 4'd5;

  // Effective format, derived from the configuration registers.
  typedef struct packed {
    logic [6:0]  n;     // total width, clamped
    logic [3:0]  e;     // exponent width, clamped
    logic [6:0]  f;     // fraction width
    logic [10:0] maxe;  // all-ones exponent
    logic [9:0]  bias;
  } fmt_t;

  // Stage 1 -> stage 2: normalised operand.
  typedef struct packed {
    logic        sign;
    logic        special;   // inf or NaN
    logic        zero;
    logic [52:0] sig;       // hidden one at bit 52
    logic [12:0] x;         // unbiased exponent, signed
  } norm_t;

  // Stage 2 -> stage 3: rounded operand.
  typedef struct packed {
    logic        sign;
    logic        special;
    logic        zero;
    logic [62:0] frac;      // right-aligned fraction
    logic [13:0] b;         // biased exponent, signed
  } rnd_t;

endpackage

// ----- rtl/double_to_custom_float_converter_core.sv -----
// Top level of the binary64 to narrow float converter: config, pipeline, output.
// Depends on dtcf_pkg, dtcf_norm, dtcf_round, dtcf_pack.
`timescale 1ns / 1ps

// Converts one binary64 pattern per cycle into a float of total_width bits
// with exponent_width exponent bits, rounding to nearest even and flushing to
// signed zero or infinity with flags. The input is registered and then passes
// three register stages (unpack and normalise, round, pack), and a new item is
// taken every cycle while the output register is empty or its result is taken.
// A stall on the master side holds all stages.
// Configuration writes take effect through the format registers and then the
// registered derived format, and must only be made while the pipe is empty.
module double_to_custom_float_converter_core #(
  parameter int unsigned MAX_OUT_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [dtcf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dtcf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // source_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // packed_value
  output logic [1:0]  m_axis_tuser_o    // underflow_flag, overflow_flag
);
  import dtcf_pkg::*;

  localparam logic [6:0] MaxN = 7'(MAX_OUT_WIDTH);

  logic [6:0] tw_q;
  logic [3:0] ew_q;
  fmt_t       fmt_d, fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q <= TotalWidthReset;
      ew_q <= ExpWidthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTotalWidth: tw_q <= cfg_data_i;
        RegExpWidth:   ew_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the format registers and precompute derived fields.
  always_comb begin
    logic [6:0] n;
    logic [6:0] e;
    n = tw_q;
    if (n < 7'd4) n = 7'd4;
    if (n > MaxN) n = MaxN;
    e = {3'd0, ew_q};
    if (e < 7'd2) e = 7'd2;
    if (e > 7'd11) e = 7'd11;
    if (e > n - 7'd2) e = n - 7'd2;
    fmt_d.n    = n;
    fmt_d.e    = e[3:0];
    fmt_d.f    = n - 7'd1 - e;
    fmt_d.maxe = 11'((12'd1 << e) - 12'd1);
    fmt_d.bias = 10'((11'd1 << (e - 7'd1)) - 11'd1);
  end

  always_ff @(posedge clk_i) begin
    fmt_q <= fmt_d;
  end

  logic  adv;
  logic  v1_q, v2_q, v3_q;
  logic [63:0] src_q;
  norm_t norm_d, norm_q;
  rnd_t  rnd_d, rnd_q;
  logic [63:0] pk_d, pk_q;
  logic  ovf_d, unf_d, ovf_q, unf_q;
  logic  vo_q;

  assign adv = !vo_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      src_q  <= s_axis_tdata_i;
      norm_q <= norm_d;
      rnd_q  <= rnd_d;
    end
  end

  dtcf_norm u_norm (.src_i(src_q), .norm_o(norm_d));
  dtcf_round u_round (.norm_i(norm_q), .fmt_i(fmt_q), .rnd_o(rnd_d));
  dtcf_pack u_pack (
    .rnd_i(rnd_q), .fmt_i(fmt_q), .packed_o(pk_d), .ovf_o(ovf_d), .unf_o(unf_d)
  );

  // Output register sits behind stage three.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (adv) vo_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pk_q  <= pk_d;
      ovf_q <= ovf_d;
      unf_q <= unf_d;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = pk_q;
  assign m_axis_tuser_o  = {unf_q, ovf_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("both flags set");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tuser_o)))
    else $error("stalled result dropped");

endmodule

// ----- rtl/dtcf_norm.sv -----
// Stage 1: unpack the binary64 pattern and normalise subnormal inputs.
// Depends on dtcf_pkg.
`timescale 1ns / 1ps

module dtcf_norm (
  input  logic [63:0]    src_i,
  output dtcf_pkg::norm_t norm_o
);
  import dtcf_pkg::*;

  logic [10:0] bexp;
  logic [51:0] man;
  logic [5:0]  pos;
  logic [52:0] sub_sig;

  always_comb begin
    bexp = src_i[62:52];
    man  = src_i[51:0];
    pos  = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (man[i]) pos = 6'(i);
    end
    sub_sig = 53'(man) << (7'd52 - {1'b0, pos});
    norm_o.sign    = src_i[63];
    norm_o.special = (bexp == 11'h7FF);
    norm_o.zero    = (bexp == 11'd0) && (man == 52'd0);
    if (bexp == 11'd0) begin
      norm_o.sig = sub_sig;
      norm_o.x   = 13'({7'd0, pos}) - 13'd1074;
    end else begin
      norm_o.sig = {1'b1, man};
      norm_o.x   = 13'({2'd0, bexp}) - 13'd1023;
    end
  end

endmodule

// ----- rtl/dtcf_round.sv -----
// Stage 2: round the significand to the fraction width, nearest even.
// Depends on dtcf_pkg.
`timescale 1ns / 1ps

module dtcf_round (
  input  dtcf_pkg::norm_t norm_i,
  input  dtcf_pkg::fmt_t  fmt_i,
  output dtcf_pkg::rnd_t  rnd_o
);
  import dtcf_pkg::*;

  logic [5:0]  d;
  logic [52:0] q;
  logic [52:0] rem;
  logic [52:0] half;
  logic [52:0] mask;
  logic [53:0] qr;
  logic        carry;
  logic [12:0] x;

  always_comb begin
    d     = 6'd0;
    q     = '0;
    rem   = '0;
    half  = '0;
    mask  = '0;
    qr    = '0;
    carry = 1'b0;
    x     = norm_i.x;
    rnd_o.frac = '0;
    if (fmt_i.f >= 7'd52) begin
      rnd_o.frac = 63'(norm_i.sig[51:0]) << (fmt_i.f - 7'd52);
    end else begin
      d    = 6'(7'd52 - fmt_i.f);
      q    = norm_i.sig >> d;
      mask = (53'd1 << d) - 53'd1;
      rem  = norm_i.sig & mask;
      half = 53'd1 << (d - 6'd1);
      qr   = {1'b0, q};
      if (rem > half || (rem == half && q[0])) qr = qr + 54'd1;
      carry = qr[fmt_i.f[5:0] + 6'd1];
      if (carry) begin
        qr = qr >> 1;
        x  = x + 13'd1;
      end
      rnd_o.frac = 63'(qr & ((54'd1 << fmt_i.f[5:0]) - 54'd1));
    end
    rnd_o.sign    = norm_i.sign;
    rnd_o.special = norm_i.special;
    rnd_o.zero    = norm_i.zero;
    rnd_o.b       = {x[12], x} + 14'({4'd0, fmt_i.bias});
  end

endmodule

// ----- rtl/dtcf_pack.sv -----
// Stage 3: range check and packing of sign, exponent and fraction.
// Depends on dtcf_pkg.
`timescale 1ns / 1ps

module dtcf_pack (
  input  dtcf_pkg::rnd_t rnd_i,
  input  dtcf_pkg::fmt_t fmt_i,
  output logic [63:0]    packed_o,
  output logic           ovf_o,
  output logic           unf_o
);
  import dtcf_pkg::*;

  logic [63:0] signpart;
  logic [63:0] inf_val;
  logic        big;
  logic        tiny;

  always_comb begin
    signpart = 64'(rnd_i.sign) << (fmt_i.n - 7'd1);
    inf_val  = signpart | (64'(fmt_i.maxe) << fmt_i.f);
    big      = !rnd_i.b[13] && (rnd_i.b >= 14'({3'd0, fmt_i.maxe}));
    tiny     = rnd_i.b[13] || (rnd_i.b == 14'd0);
    ovf_o    = 1'b0;
    unf_o    = 1'b0;
    if (rnd_i.special) begin
      packed_o = inf_val;
      ovf_o    = 1'b1;
    end else if (rnd_i.zero) begin
      packed_o = signpart;
    end else if (big) begin
      packed_o = inf_val;
      ovf_o    = 1'b1;
    end else if (tiny) begin
      packed_o = signpart;
      unf_o    = 1'b1;
    end else begin
      packed_o = signpart | (64'(rnd_i.b[10:0]) << fmt_i.f) | 64'(rnd_i.frac);
    end
  end

endmodule
